// ===== rtl/core/ecal_pkg.sv =====
package ecal_pkg;

	// register stages from input to result
	localparam int NumStages = 9;

	typedef logic [NumStages-1:0] stage_en_t;

	// seconds to whole days: shift out 2^7, then divide by 675
	localparam logic [16:0] SecsPerDay = 17'd86400;
	localparam int DayShift = 7;
	localparam int DayOdd = 675;
	localparam int DayRecipShift = 40;
	localparam logic [30:0] DayRecip = 31'((41'd1 << DayRecipShift) / DayOdd);

	// days since 1968-01-01 are split into 4-year cycles
	localparam logic [16:0] EpochShift = 17'd731;
	localparam logic [15:0] DaysPerCycle = 16'd1461;
	localparam int CycRecipShift = 32;
	localparam logic [21:0] CycRecip = 22'((33'd1 << CycRecipShift) / 1461);
	// first day after 2100-02-28, counted from 1970; a dummy leap day is inserted there
	localparam logic [15:0] SkipLeapDay = 16'd47541;
	localparam logic [7:0] BaseYearRel = 8'd68;
	localparam logic [7:0] Year2100Rel = 8'd200;
	localparam logic [8:0] MarchFirstLeap = 9'd60;

	localparam logic [10:0] YearEnd0 = 11'd366;
	localparam logic [10:0] YearEnd1 = 11'd731;
	localparam logic [10:0] YearEnd2 = 11'd1096;

	localparam logic [16:0] EpochWeekday = 17'd4;
	localparam logic [3:0] DaysPerWeek = 4'd7;

	localparam logic [16:0] SecsPerHour = 17'd3600;
	localparam int HourRecipShift = 24;
	localparam logic [12:0] HourRecip = 13'((25'd1 << HourRecipShift) / 3600);
	localparam logic [11:0] SecsPerMin = 12'd60;
	localparam int MinRecipShift = 16;
	localparam logic [10:0] MinRecip = 11'((17'd1 << MinRecipShift) / 60);

	localparam logic [3:0] MonthsPerYear = 4'd12;

	// day of year on which month m starts
	function automatic logic [8:0] month_start(input logic leap, input logic [3:0] m);
		logic [8:0] s;
		case (m)
			4'd0: s = 9'd0;
			4'd1: s = 9'd31;
			4'd2: s = 9'd59;
			4'd3: s = 9'd90;
			4'd4: s = 9'd120;
			4'd5: s = 9'd151;
			4'd6: s = 9'd181;
			4'd7: s = 9'd212;
			4'd8: s = 9'd243;
			4'd9: s = 9'd273;
			4'd10: s = 9'd304;
			4'd11: s = 9'd334;
			default: s = 9'd0;
		endcase
		if (leap && m >= 4'd2) begin
			s = s + 9'd1;
		end
		return s;
	endfunction

endpackage

// ===== rtl/core/ecal_day_split.sv =====
module ecal_day_split (
	input  logic              clk,
	input  ecal_pkg::stage_en_t en,
	input  logic [31:0]       epoch_seconds,
	output logic [15:0]       days_s3,
	output logic [16:0]       rem_s3
);
	import ecal_pkg::*;

	logic [55:0] prod_s1;
	logic [31:0] secs_s1;
	logic [15:0] q_s2;
	logic [31:0] qm_s2;
	logic [31:0] secs_s2;
	logic [15:0] q_est;
	logic [31:0] r_est;

	assign q_est = prod_s1[DayRecipShift+15:DayRecipShift];
	assign r_est = secs_s2 - qm_s2;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			prod_s1 <= {31'd0, epoch_seconds[31:DayShift]} * {25'd0, DayRecip};
			secs_s1 <= epoch_seconds;
		end
		if (en[1]) begin
			q_s2 <= q_est;
			qm_s2 <= {16'd0, q_est} * {15'd0, SecsPerDay};
			secs_s2 <= secs_s1;
		end
		// estimate is low by at most one day
		if (en[2]) begin
			if (r_est >= {15'd0, SecsPerDay}) begin
				days_s3 <= q_s2 + 16'd1;
				rem_s3 <= r_est[16:0] - SecsPerDay;
			end else begin
				days_s3 <= q_s2;
				rem_s3 <= r_est[16:0];
			end
		end
	end

endmodule

// ===== rtl/core/ecal_date.sv =====
module ecal_date (
	input  logic              clk,
	input  ecal_pkg::stage_en_t en,
	input  logic [15:0]       days_s3,
	output logic [7:0]        year_s9,
	output logic [3:0]        month_s9,
	output logic [4:0]        mday_s9,
	output logic [8:0]        yday_s9,
	output logic [2:0]        wday_s9
);
	import ecal_pkg::*;

	logic [15:0] d_s4;
	logic [37:0] dprod_s4;
	logic [2:0]  wday_s4;
	logic [15:0] d_s5;
	logic [5:0]  c_s5;
	logic [15:0] cm_s5;
	logic [2:0]  wday_s5;
	logic [5:0]  c_s6;
	logic [10:0] r_s6;
	logic [2:0]  wday_s6;
	logic [7:0]  year_s7;
	logic [8:0]  yday_s7;
	logic        leap_s7;
	logic [2:0]  wday_s7;
	logic [7:0]  year_s8;
	logic [8:0]  yday_s8;
	logic [3:0]  month_s8;
	logic [4:0]  mday_s8;
	logic [2:0]  wday_s8;

	logic [16:0] d_shift;
	logic [16:0] wk_t;
	logic [5:0]  wk_g;
	logic [3:0]  wk_f;
	logic [2:0]  wk_w;
	logic [5:0]  c_est;
	logic [15:0] r_est;
	logic [1:0]  yoff;
	logic [10:0] ystart;
	logic [3:0]  mon;
	logic [8:0]  mday_w;

	// dummy Feb 29 in 2100 keeps the 4-year cycle uniform
	always_comb begin
		d_shift = {1'b0, days_s3} + EpochShift;
		if (days_s3 >= SkipLeapDay) begin
			d_shift = d_shift + 17'd1;
		end
	end

	// (days + 4) mod 7, folding octal digits since 8 = 1 mod 7
	always_comb begin
		wk_t = {1'b0, days_s3} + EpochWeekday;
		wk_g = {3'd0, wk_t[2:0]} + {3'd0, wk_t[5:3]} + {3'd0, wk_t[8:6]}
			+ {3'd0, wk_t[11:9]} + {3'd0, wk_t[14:12]} + {4'd0, wk_t[16:15]};
		wk_f = {1'b0, wk_g[5:3]} + {1'b0, wk_g[2:0]};
		if (wk_f >= DaysPerWeek) begin
			wk_f = wk_f - DaysPerWeek;
		end
		wk_w = wk_f[2:0];
	end

	assign c_est = dprod_s4[CycRecipShift+5:CycRecipShift];
	assign r_est = d_s5 - cm_s5;

	always_comb begin
		if (r_s6 < YearEnd0) begin
			yoff = 2'd0;
			ystart = 11'd0;
		end else if (r_s6 < YearEnd1) begin
			yoff = 2'd1;
			ystart = YearEnd0;
		end else if (r_s6 < YearEnd2) begin
			yoff = 2'd2;
			ystart = YearEnd1;
		end else begin
			yoff = 2'd3;
			ystart = YearEnd2;
		end
	end

	always_comb begin
		mon = 4'd0;
		for (int m = 1; m < 12; m++) begin
			if (yday_s7 >= month_start(leap_s7, 4'(m))) begin
				mon = mon + 4'd1;
			end
		end
		mday_w = yday_s7 - month_start(leap_s7, mon) + 9'd1;
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			d_s4 <= d_shift[15:0];
			dprod_s4 <= {22'd0, d_shift[15:0]} * {16'd0, CycRecip};
			wday_s4 <= wk_w;
		end
		if (en[4]) begin
			d_s5 <= d_s4;
			c_s5 <= c_est;
			cm_s5 <= {10'd0, c_est} * DaysPerCycle;
			wday_s5 <= wday_s4;
		end
		if (en[5]) begin
			if (r_est >= DaysPerCycle) begin
				c_s6 <= c_s5 + 6'd1;
				r_s6 <= 11'(r_est - DaysPerCycle);
			end else begin
				c_s6 <= c_s5;
				r_s6 <= r_est[10:0];
			end
			wday_s6 <= wday_s5;
		end
		if (en[6]) begin
			year_s7 <= BaseYearRel + {c_s6, 2'b00} + {6'd0, yoff};
			yday_s7 <= 9'(r_s6 - ystart);
			leap_s7 <= (yoff == 2'd0);
			wday_s7 <= wday_s6;
		end
		if (en[7]) begin
			year_s8 <= year_s7;
			yday_s8 <= yday_s7;
			month_s8 <= mon;
			mday_s8 <= mday_w[4:0];
			wday_s8 <= wday_s7;
		end
		// take the dummy leap day back out of 2100's day count
		if (en[8]) begin
			year_s9 <= year_s8;
			month_s9 <= month_s8;
			mday_s9 <= mday_s8;
			wday_s9 <= wday_s8;
			if (year_s8 == Year2100Rel && yday_s8 >= MarchFirstLeap) begin
				yday_s9 <= yday_s8 - 9'd1;
			end else begin
				yday_s9 <= yday_s8;
			end
		end
	end

endmodule

// ===== rtl/core/ecal_clock.sv =====
module ecal_clock (
	input  logic              clk,
	input  ecal_pkg::stage_en_t en,
	input  logic [16:0]       rem_s3,
	output logic [4:0]        hour_s9,
	output logic [5:0]        min_s9,
	output logic [5:0]        sec_s9
);
	import ecal_pkg::*;

	logic [16:0] rem_s4;
	logic [29:0] hprod_s4;
	logic [16:0] rem_s5;
	logic [4:0]  h_s5;
	logic [16:0] hm_s5;
	logic [4:0]  hour_s6;
	logic [11:0] rh_s6;
	logic [4:0]  hour_s7;
	logic [11:0] rh_s7;
	logic [22:0] mprod_s7;
	logic [4:0]  hour_s8;
	logic [11:0] rh_s8;
	logic [5:0]  m_s8;
	logic [11:0] mm_s8;

	logic [4:0]  h_est;
	logic [16:0] rh_est;
	logic [5:0]  m_est;
	logic [11:0] s_est;

	assign h_est = hprod_s4[HourRecipShift+4:HourRecipShift];
	assign rh_est = rem_s5 - hm_s5;
	assign m_est = mprod_s7[MinRecipShift+5:MinRecipShift];
	assign s_est = rh_s8 - mm_s8;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			rem_s4 <= rem_s3;
			hprod_s4 <= {13'd0, rem_s3} * {17'd0, HourRecip};
		end
		if (en[4]) begin
			rem_s5 <= rem_s4;
			h_s5 <= h_est;
			hm_s5 <= {12'd0, h_est} * SecsPerHour;
		end
		if (en[5]) begin
			if (rh_est >= SecsPerHour) begin
				hour_s6 <= h_s5 + 5'd1;
				rh_s6 <= 12'(rh_est - SecsPerHour);
			end else begin
				hour_s6 <= h_s5;
				rh_s6 <= rh_est[11:0];
			end
		end
		if (en[6]) begin
			hour_s7 <= hour_s6;
			rh_s7 <= rh_s6;
			mprod_s7 <= {11'd0, rh_s6} * {12'd0, MinRecip};
		end
		if (en[7]) begin
			hour_s8 <= hour_s7;
			rh_s8 <= rh_s7;
			m_s8 <= m_est;
			mm_s8 <= {6'd0, m_est} * SecsPerMin;
		end
		if (en[8]) begin
			hour_s9 <= hour_s8;
			if (s_est >= SecsPerMin) begin
				min_s9 <= m_s8 + 6'd1;
				sec_s9 <= 6'(s_est - SecsPerMin);
			end else begin
				min_s9 <= m_s8;
				sec_s9 <= s_est[5:0];
			end
		end
	end

endmodule

// ===== rtl/core/epoch_seconds_to_calendar_top.sv =====
// Throughput: one word per cycle while out_stall is low. Words pass through
// nine register stages to the output register; each stage loads whenever it
// is empty or its successor loads, so bubbles close up while the output stalls.
// Reset: arst_n clears the stage valid bits asynchronously; data registers
// are not reset.
module epoch_seconds_to_calendar_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] epoch_seconds,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  year_since_1900,
	output logic [3:0]  month_index,
	output logic [4:0]  day_of_month,
	output logic [8:0]  day_of_year,
	output logic [2:0]  weekday,
	output logic [4:0]  hour_of_day,
	output logic [5:0]  minute_of_hour,
	output logic [5:0]  second_of_minute
);
	import ecal_pkg::*;

	localparam int Last = NumStages - 1;

	stage_en_t         en;
	logic [Last:0]     valid_q;
	logic [15:0]       days_s3;
	logic [16:0]       rem_s3;

	always_comb begin
		en[Last] = !valid_q[Last] || !out_stall;
		for (int k = Last - 1; k >= 0; k--) begin
			en[k] = !valid_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (en[0]) begin
				valid_q[0] <= in_valid;
			end
			for (int k = 1; k <= Last; k++) begin
				if (en[k]) begin
					valid_q[k] <= valid_q[k-1];
				end
			end
		end
	end

	assign in_stall = !en[0];
	assign out_valid = valid_q[Last];

	ecal_day_split u_split (
		.clk           (clk),
		.en            (en),
		.epoch_seconds (epoch_seconds),
		.days_s3       (days_s3),
		.rem_s3        (rem_s3)
	);

	ecal_date u_date (
		.clk      (clk),
		.en       (en),
		.days_s3  (days_s3),
		.year_s9  (year_since_1900),
		.month_s9 (month_index),
		.mday_s9  (day_of_month),
		.yday_s9  (day_of_year),
		.wday_s9  (weekday)
	);

	ecal_clock u_clock (
		.clk     (clk),
		.en      (en),
		.rem_s3  (rem_s3),
		.hour_s9 (hour_of_day),
		.min_s9  (minute_of_hour),
		.sec_s9  (second_of_minute)
	);

`ifndef SYNTHESIS
	// a full pipeline with a stalled output cannot take a word
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(&valid_q && out_stall) |-> in_stall)
		else $error("input accepted while pipeline full and stalled");

	// an accepted word reaches stage one
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> valid_q[0])
		else $error("accepted word lost at entry");

	a_ranges: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (month_index < MonthsPerYear && day_of_month != 5'd0
			&& weekday < 3'd7 && hour_of_day < 5'd24 && minute_of_hour < 6'd60
			&& second_of_minute < 6'd60 && day_of_year <= 9'd365))
		else $error("result field out of range");

	a_feb: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && month_index == 4'd1) |-> day_of_month <= 5'd29)
		else $error("february day out of range");

	a_year_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && day_of_year == 9'd365) |-> (month_index == 4'd11
			&& day_of_month == 5'd31))
		else $error("day 365 is not december 31");
`endif

endmodule
